>>> sv/tid_pkg.sv
// Shared types, codes and helpers for the TIFF directory entry decoder.
// No dependencies; every other file imports this package.
package tid_pkg;

  localparam int unsigned DataW = 64;

  // Configuration register indexes
  localparam logic [7:0] REG_BIG_ENDIAN    = 8'd0;
  localparam logic [7:0] REG_BIG_TIFF      = 8'd1;
  localparam logic [7:0] REG_FILE_SIZE     = 8'd2;
  localparam logic [7:0] REG_MAX_TAG_COUNT = 8'd3;

  localparam logic [DataW-1:0] MaxTagCountReset = 64'd1048576;

  // Supported field type codes
  localparam logic [15:0] TYPE_BYTE  = 16'd1;
  localparam logic [15:0] TYPE_SHORT = 16'd3;
  localparam logic [15:0] TYPE_LONG  = 16'd4;
  localparam logic [15:0] TYPE_LONG8 = 16'd16;

  // Value area sizes in bytes
  localparam logic [3:0] AREA_CLASSIC = 4'd4;
  localparam logic [3:0] AREA_BIG     = 4'd8;

  typedef enum logic [2:0] {
    ST_INLINE      = 3'd0,
    ST_OUT_OF_LINE = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_SKIPPED     = 3'd3,
    ST_OVERFLOW    = 3'd4,
    ST_OUT_OF_FILE = 3'd5,
    ST_COUNT_LIMIT = 3'd6
  } status_e;

  typedef struct packed {
    logic             big_endian;
    logic             big_tiff;
    logic [DataW-1:0] file_size;
    logic [DataW-1:0] max_tag_count;
  } cfg_t;

  // After header decode
  typedef struct packed {
    logic [15:0]      tag;
    logic [15:0]      type_code;
    logic [DataW-1:0] count;
    logic [DataW-1:0] area;    // value area bytes, first byte in bits 7:0
  } hdr_t;

  // After size and bounds arithmetic
  typedef struct packed {
    hdr_t             hdr;
    logic             supported;
    logic [1:0]       esize_log;
    logic             overflow;
    logic             fits;
    logic             cnt_over_max;
    logic             cnt_zero;
    logic             off_over_fs;
    logic [DataW-1:0] total;
    logic [DataW-1:0] offset;
    logic [DataW-1:0] room;
  } size_t;

  // Ready for the emitter
  typedef struct packed {
    hdr_t             hdr;
    logic [1:0]       esize_log;
    status_e          status;
    logic [3:0]       n_results;
    logic [DataW-1:0] data_offset;
    logic [DataW-1:0] data_bytes;
  } ent_t;

  // Read n bytes (1..8) from the start of raw in the given byte order.
  function automatic logic [DataW-1:0] read_bytes(input logic [DataW-1:0] raw,
                                                  input logic [3:0] n,
                                                  input logic be);
    logic [DataW-1:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        if (be) begin
          v = {v[DataW-9:0], raw[8*i +: 8]};
        end else begin
          v[8*i +: 8] = raw[8*i +: 8];
        end
      end
    end
    return v;
  endfunction

endpackage

>>> sv/tid_hdr_decode.sv
// Pipeline stage one: pull tag, type, count and value area out of a raw entry.
// Depends on tid_pkg.
module tid_hdr_decode import tid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [63:0] entry_bytes_low_i,
  input  logic [63:0] entry_bytes_mid_i,
  input  logic [31:0] entry_bytes_high_i,
  output logic        valid_o,
  input  logic        stall_i,
  output hdr_t        hdr_o
);

  logic valid_q;
  hdr_t hdr_q, hdr_d;
  logic adv;

  assign adv     = !valid_q || !stall_i;
  assign stall_o = !adv;

  always_comb begin
    hdr_d.tag = 16'(read_bytes({48'd0, entry_bytes_low_i[15:0]}, 4'd2,
                               cfg_i.big_endian));
    hdr_d.type_code = 16'(read_bytes({48'd0, entry_bytes_low_i[31:16]}, 4'd2,
                                     cfg_i.big_endian));
    if (cfg_i.big_tiff) begin
      hdr_d.count = read_bytes({entry_bytes_mid_i[31:0], entry_bytes_low_i[63:32]},
                               4'd8, cfg_i.big_endian);
      hdr_d.area  = {entry_bytes_high_i, entry_bytes_mid_i[63:32]};
    end else begin
      hdr_d.count = read_bytes({32'd0, entry_bytes_low_i[63:32]}, 4'd4,
                               cfg_i.big_endian);
      hdr_d.area  = {32'd0, entry_bytes_mid_i[31:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      hdr_q <= hdr_d;
    end
  end

  assign valid_o = valid_q;
  assign hdr_o   = hdr_q;

endmodule

>>> sv/tid_size_check.sv
// Pipeline stage two: element size, byte total, overflow and bounds terms.
// Depends on tid_pkg.
module tid_size_check import tid_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  output logic  stall_o,
  input  hdr_t  hdr_i,
  output logic  valid_o,
  input  logic  stall_i,
  output size_t size_o
);

  logic  valid_q;
  size_t size_q, size_d;
  logic  adv;
  logic [3:0] area_size;

  assign adv     = !valid_q || !stall_i;
  assign stall_o = !adv;
  assign area_size = cfg_i.big_tiff ? AREA_BIG : AREA_CLASSIC;

  always_comb begin
    size_d.hdr       = hdr_i;
    size_d.supported = 1'b1;
    size_d.esize_log = 2'd0;
    size_d.overflow  = 1'b0;
    case (hdr_i.type_code)
      TYPE_BYTE:  size_d.esize_log = 2'd0;
      TYPE_SHORT: begin
        size_d.esize_log = 2'd1;
        size_d.overflow  = hdr_i.count[63];
      end
      TYPE_LONG: begin
        size_d.esize_log = 2'd2;
        size_d.overflow  = |hdr_i.count[63:62];
      end
      TYPE_LONG8: begin
        size_d.esize_log = 2'd3;
        size_d.overflow  = |hdr_i.count[63:61];
      end
      default: size_d.supported = 1'b0;
    endcase
    size_d.total        = hdr_i.count << size_d.esize_log;
    size_d.fits         = (size_d.total[63:4] == '0) && (size_d.total[3:0] <= area_size);
    size_d.cnt_over_max = hdr_i.count > cfg_i.max_tag_count;
    size_d.cnt_zero     = hdr_i.count == '0;
    size_d.offset       = read_bytes(hdr_i.area, area_size, cfg_i.big_endian);
    size_d.off_over_fs  = size_d.offset > cfg_i.file_size;
    size_d.room         = cfg_i.file_size - size_d.offset;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      size_q <= size_d;
    end
  end

  assign valid_o = valid_q;
  assign size_o  = size_q;

endmodule

>>> sv/tid_classify.sv
// Pipeline stage three: pick the status and the number of results per entry.
// Depends on tid_pkg.
module tid_classify import tid_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  size_t size_i,
  output logic  valid_o,
  input  logic  stall_i,
  output ent_t  ent_o
);

  logic valid_q;
  ent_t ent_q, ent_d;
  logic adv;

  assign adv     = !valid_q || !stall_i;
  assign stall_o = !adv;

  always_comb begin
    ent_d.hdr         = size_i.hdr;
    ent_d.esize_log   = size_i.esize_log;
    ent_d.n_results   = 4'd1;
    ent_d.data_offset = '0;
    ent_d.data_bytes  = '0;
    if (!size_i.supported) begin
      ent_d.status = ST_SKIPPED;
    end else if (size_i.overflow) begin
      ent_d.status = ST_OVERFLOW;
    end else if (size_i.fits) begin
      if (size_i.cnt_over_max) begin
        ent_d.status = ST_COUNT_LIMIT;
      end else if (size_i.cnt_zero) begin
        ent_d.status = ST_EMPTY;
      end else begin
        // a fitting count is 1..8
        ent_d.status    = ST_INLINE;
        ent_d.n_results = size_i.hdr.count[3:0];
      end
    end else begin
      ent_d.data_offset = size_i.offset;
      ent_d.data_bytes  = size_i.total;
      if (size_i.off_over_fs || (size_i.total > size_i.room)) begin
        ent_d.status = ST_OUT_OF_FILE;
      end else if (size_i.cnt_over_max) begin
        ent_d.status = ST_COUNT_LIMIT;
      end else begin
        ent_d.status = ST_OUT_OF_LINE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      ent_q <= ent_d;
    end
  end

  assign valid_o = valid_q;
  assign ent_o   = ent_q;

endmodule

>>> sv/tid_emit.sv
// Output stage: hold one classified entry; emit a result a cycle unless stalled.
// Depends on tid_pkg.
module tid_emit import tid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        big_endian_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  ent_t        ent_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] tag_number_o,
  output logic [15:0] type_code_o,
  output logic [63:0] element_count_o,
  output logic [2:0]  element_index_o,
  output logic [63:0] element_value_o,
  output logic [63:0] data_offset_o,
  output logic [63:0] data_bytes_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  logic       valid_q;
  ent_t       ent_q;
  logic [2:0] idx_q, idx_d;
  logic       is_last, take, load, is_inline;
  logic [2:0] byte_pos;
  logic [3:0] esize;

  assign is_last   = ({1'b0, idx_q} + 4'd1) == ent_q.n_results;
  assign take      = valid_q && !out_stall_i;
  assign load      = !valid_q || (take && is_last);
  assign stall_o   = !load;
  assign is_inline = ent_q.status == ST_INLINE;
  assign idx_d     = load ? 3'd0 : (take ? idx_q + 3'd1 : idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      ent_q <= ent_i;
    end
  end

  // element i starts at byte i * size within the value area
  assign byte_pos = idx_q << ent_q.esize_log;
  assign esize    = 4'd1 << ent_q.esize_log;

  assign out_valid_o     = valid_q;
  assign tag_number_o    = ent_q.hdr.tag;
  assign type_code_o     = ent_q.hdr.type_code;
  assign element_count_o = ent_q.hdr.count;
  assign element_index_o = is_inline ? idx_q : 3'd0;
  assign element_value_o = is_inline ?
                           read_bytes(ent_q.hdr.area >> {byte_pos, 3'b000}, esize,
                                      big_endian_i) : 64'd0;
  assign data_offset_o   = ent_q.data_offset;
  assign data_bytes_o    = ent_q.data_bytes;
  assign status_o        = ent_q.status;
  assign last_o          = is_last;

  // anything but an inline value is a single result
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_INLINE)) |-> (last_o && element_index_o == 3'd0))
    else $error("non-inline result not marked last");

  // inline results stay within the declared count
  a_index_in_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_INLINE)) |->
      ({61'd0, element_index_o} < element_count_o))
    else $error("inline index beyond element count");

  // a taken result that is not last is followed by the next element at once
  a_next_element: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=>
      (out_valid_o && element_index_o == $past(element_index_o) + 3'd1))
    else $error("inline element sequence broken");

endmodule

>>> sv/tiff_ifd_entry_decoder.sv
// Top level of the TIFF directory entry decoder: configuration registers and
// the four pipeline stages. Depends on tid_pkg and the tid_* stage modules.
//
// Usage
//   Input channel: one raw directory entry per request (entry_bytes_*_i),
//   accepted on a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: one result per inline element, else one per request, on
//   out_valid_o / out_stall_i; last_o marks the final result of an entry.
//   Configuration: cfg_we_i with cfg_index_i and cfg_wdata_i writes one register
//   per edge (0 byte order, 1 BigTIFF layout, 2 file size, 3 count limit);
//   other indexes are dropped. Write only while the pipeline is empty.
// Pipeline
//   Decode, size/bounds arithmetic and classification take one register stage
//   each, and the output stage registers the entry before its first result
//   appears on out_valid_o.
//   The output stage emits one result per cycle while out_stall_i is low, so an
//   entry with k inline elements (1 to 8) yields k results and any other entry
//   one; entries may arrive back to back.
// Reset and stall
//   Reset empties every stage and loads the register defaults (little endian,
//   classic, file size 0, count limit 1048576).
//   While out_stall_i is high the current result holds; the stages behind it
//   fill up and then in_stall_o rises. Nothing is dropped or repeated.
module tiff_ifd_entry_decoder import tid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] entry_bytes_low_i,
  input  logic [63:0] entry_bytes_mid_i,
  input  logic [31:0] entry_bytes_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] tag_number_o,
  output logic [15:0] type_code_o,
  output logic [63:0] element_count_o,
  output logic [2:0]  element_index_o,
  output logic [63:0] element_value_o,
  output logic [63:0] data_offset_o,
  output logic [63:0] data_bytes_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  cfg_t cfg_q;

  logic  s1_valid, s1_stall;
  hdr_t  s1_hdr;
  logic  s2_valid, s2_stall;
  size_t s2_size;
  logic  s3_valid, s3_stall;
  ent_t  s3_ent;

  // Config regs: user keeps static while entries are in flight, not enforced
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.big_endian    <= 1'b0;
      cfg_q.big_tiff      <= 1'b0;
      cfg_q.file_size     <= '0;
      cfg_q.max_tag_count <= MaxTagCountReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BIG_ENDIAN:    cfg_q.big_endian    <= cfg_wdata_i[0];
        REG_BIG_TIFF:      cfg_q.big_tiff      <= cfg_wdata_i[0];
        REG_FILE_SIZE:     cfg_q.file_size     <= cfg_wdata_i;
        REG_MAX_TAG_COUNT: cfg_q.max_tag_count <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage one: byte order and field extraction
  tid_hdr_decode u_hdr_decode (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .valid_i            (in_valid_i),
    .stall_o            (in_stall_o),
    .entry_bytes_low_i  (entry_bytes_low_i),
    .entry_bytes_mid_i  (entry_bytes_mid_i),
    .entry_bytes_high_i (entry_bytes_high_i),
    .valid_o            (s1_valid),
    .stall_i            (s1_stall),
    .hdr_o              (s1_hdr)
  );

  // Stage two: element size, total bytes, bounds comparisons
  tid_size_check u_size_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s1_valid),
    .stall_o (s1_stall),
    .hdr_i   (s1_hdr),
    .valid_o (s2_valid),
    .stall_i (s2_stall),
    .size_o  (s2_size)
  );

  // Stage three: status and result count
  tid_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .stall_o (s2_stall),
    .size_i  (s2_size),
    .valid_o (s3_valid),
    .stall_i (s3_stall),
    .ent_o   (s3_ent)
  );

  // Output stage: one result per cycle unless stalled; next entry on the last
  tid_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .big_endian_i    (cfg_q.big_endian),
    .valid_i         (s3_valid),
    .stall_o         (s3_stall),
    .ent_i           (s3_ent),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .tag_number_o    (tag_number_o),
    .type_code_o     (type_code_o),
    .element_count_o (element_count_o),
    .element_index_o (element_index_o),
    .element_value_o (element_value_o),
    .data_offset_o   (data_offset_o),
    .data_bytes_o    (data_bytes_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for tiff_ifd_entry_decoder: directed and random directory
// entries under several register settings, checked against an in-bench decoder.
// Depends on tid_pkg (sv/tid_pkg.sv) and the decoder RTL.
`timescale 1ns / 100ps

module tb;
  import tid_pkg::*;

  // An index past the end of the register map; writes to it must be dropped
  localparam logic [7:0] RegUnused = 8'hC4;

  // One decoded result, as the output channel presents it
  typedef struct {
    logic [15:0] tag;
    logic [15:0] code;
    logic [63:0] count;
    logic [2:0]  index;
    logic [63:0] value;
    logic [63:0] offset;
    logic [63:0] nbytes;
    status_e     status;
    logic        last;
  } dir_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_index_i;
  logic [63:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] entry_bytes_low_i;
  logic [63:0] entry_bytes_mid_i;
  logic [31:0] entry_bytes_high_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] tag_number_o;
  logic [15:0] type_code_o;
  logic [63:0] element_count_o;
  logic [2:0]  element_index_o;
  logic [63:0] element_value_o;
  logic [63:0] data_offset_o;
  logic [63:0] data_bytes_o;
  logic [2:0]  status_o;
  logic        last_o;

  tiff_ifd_entry_decoder dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .entry_bytes_low_i  (entry_bytes_low_i),
    .entry_bytes_mid_i  (entry_bytes_mid_i),
    .entry_bytes_high_i (entry_bytes_high_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .tag_number_o       (tag_number_o),
    .type_code_o        (type_code_o),
    .element_count_o    (element_count_o),
    .element_index_o    (element_index_o),
    .element_value_o    (element_value_o),
    .data_offset_o      (data_offset_o),
    .data_bytes_o       (data_bytes_o),
    .status_o           (status_o),
    .last_o             (last_o)
  );

  // Bench copy of the register file, results still owed by the decoder, and the
  // idling and stalling odds of the current phase (percent of cycles)
  cfg_t          model_cfg;
  dir_result_t   pending_results[$];
  int unsigned   mismatch_count;
  int unsigned   idle_pct;
  int unsigned   stall_pct;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver side: stall at random with the odds of the current phase
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < stall_pct);
  end

  function automatic logic [159:0] rand_bits();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Append one result to the tail of the owed list
  function automatic void owe_result(input dir_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Read n bytes from position pos of the entry in the configured byte order
  function automatic logic [63:0] field_at(input logic [159:0] e, input int pos, input int n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < n; i++) begin
      if (model_cfg.big_endian) begin
        v = {v[55:0], e[8*(pos+i) +: 8]};
      end else begin
        v[8*i +: 8] = e[8*(pos+i) +: 8];
      end
    end
    return v;
  endfunction

  // Write n bytes of v at position pos in the configured byte order
  function automatic logic [159:0] put_field(input logic [159:0] e, input int pos, input int n,
                                             input logic [63:0] v);
    for (int i = 0; i < n; i++) begin
      e[8*(pos+i) +: 8] = model_cfg.big_endian ? v[8*(n-1-i) +: 8] : v[8*i +: 8];
    end
    return e;
  endfunction

  function automatic int unsigned elem_bytes(input logic [15:0] code);
    case (code)
      TYPE_BYTE:  return 1;
      TYPE_SHORT: return 2;
      TYPE_LONG:  return 4;
      TYPE_LONG8: return 8;
      default:    return 0;
    endcase
  endfunction

  // Decode one entry under the bench registers and queue the results it owes
  function automatic void decode_entry(input logic [159:0] e);
    dir_result_t r;
    int unsigned esize;
    int unsigned area_pos;
    int unsigned area_size;
    logic [63:0] total;
    r.tag  = 16'(field_at(e, 0, 2));
    r.code = 16'(field_at(e, 2, 2));
    if (model_cfg.big_tiff) begin
      r.count   = field_at(e, 4, 8);
      area_pos  = 12;
      area_size = 8;
    end else begin
      r.count   = field_at(e, 4, 4);
      area_pos  = 8;
      area_size = 4;
    end
    r.index  = '0;
    r.value  = '0;
    r.offset = '0;
    r.nbytes = '0;
    r.last   = 1'b1;
    esize = elem_bytes(r.code);
    if (esize == 0) begin
      r.status = ST_SKIPPED;
      owe_result(r);
      return;
    end
    if (r.count > (~64'd0) / 64'(esize)) begin
      r.status = ST_OVERFLOW;
      owe_result(r);
      return;
    end
    total = r.count * 64'(esize);
    if (total <= 64'(area_size)) begin
      // Inline: count limit first, then the empty case, then one result per element
      if (r.count > model_cfg.max_tag_count) begin
        r.status = ST_COUNT_LIMIT;
        owe_result(r);
        return;
      end
      if (r.count == 0) begin
        r.status = ST_EMPTY;
        owe_result(r);
        return;
      end
      for (int i = 0; 64'(i) < r.count; i++) begin
        r.index  = 3'(i);
        r.value  = field_at(e, area_pos + i * esize, esize);
        r.status = ST_INLINE;
        r.last   = (64'(i + 1) == r.count);
        owe_result(r);
      end
      return;
    end
    r.offset = field_at(e, area_pos, area_size);
    r.nbytes = total;
    if (r.offset > model_cfg.file_size || total > model_cfg.file_size - r.offset) begin
      r.status = ST_OUT_OF_FILE;
    end else if (r.count > model_cfg.max_tag_count) begin
      r.status = ST_COUNT_LIMIT;
    end else begin
      r.status = ST_OUT_OF_LINE;
    end
    owe_result(r);
  endfunction

  function automatic string field_label(input int k);
    case (k)
      0:       return "tag_number";
      1:       return "type_code";
      2:       return "element_count";
      3:       return "element_index";
      4:       return "element_value";
      5:       return "data_offset";
      6:       return "data_bytes";
      7:       return "status";
      default: return "last";
    endcase
  endfunction

  // Result checker: compare every accepted result with the oldest one owed
  always @(posedge clk_i) begin : check_results
    dir_result_t want;
    logic [63:0] want_f [9];
    logic [63:0] got_f  [9];
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result tag %0h status %0d", $time, tag_number_o, status_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        want_f = '{64'(want.tag), 64'(want.code), want.count, 64'(want.index), want.value,
                   want.offset, want.nbytes, 64'(want.status), 64'(want.last)};
        got_f  = '{64'(tag_number_o), 64'(type_code_o), element_count_o,
                   64'(element_index_o), element_value_o, data_offset_o, data_bytes_o,
                   64'(status_o), 64'(last_o)};
        for (int k = 0; k < 9; k++) begin
          if (got_f[k] !== want_f[k]) begin
            $display("%0t: %s expected %0h got %0h", $time, field_label(k), want_f[k],
                     got_f[k]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Present one request, idling first at the phase's odds, and hold it until taken
  task automatic send_entry(input logic [159:0] e);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      {entry_bytes_high_i, entry_bytes_mid_i, entry_bytes_low_i} = rand_bits();
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    {entry_bytes_high_i, entry_bytes_mid_i, entry_bytes_low_i} = e;
    do @(posedge clk_i); while (in_stall_o);
    decode_entry(e);
  endtask

  // Build an entry in the current layout and byte order; unused bytes are random.
  // The value area takes either raw bytes in file order or an encoded offset.
  function automatic logic [159:0] build_entry(input logic [15:0] tag, input logic [15:0] code,
                                               input logic [63:0] count,
                                               input logic [63:0] area, input bit is_offset);
    logic [159:0] e;
    int unsigned  area_pos;
    int unsigned  area_size;
    area_pos  = model_cfg.big_tiff ? 12 : 8;
    area_size = model_cfg.big_tiff ? 8 : 4;
    e = rand_bits();
    e = put_field(e, 0, 2, 64'(tag));
    e = put_field(e, 2, 2, 64'(code));
    e = put_field(e, 4, model_cfg.big_tiff ? 8 : 4, count);
    if (is_offset) begin
      e = put_field(e, area_pos, area_size, area);
    end else begin
      for (int i = 0; i < area_size; i++) e[8*(area_pos+i) +: 8] = area[8*i +: 8];
    end
    return e;
  endfunction

  task automatic send_fields(input logic [15:0] tag, input logic [15:0] code,
                             input logic [63:0] count, input logic [63:0] area,
                             input bit is_offset);
    send_entry(build_entry(tag, code, count, area, is_offset));
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_BIG_ENDIAN:    model_cfg.big_endian    = val[0];
      REG_BIG_TIFF:      model_cfg.big_tiff      = val[0];
      REG_FILE_SIZE:     model_cfg.file_size     = val;
      REG_MAX_TAG_COUNT: model_cfg.max_tag_count = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic be, input logic big, input logic [63:0] fsize,
                            input logic [63:0] max_count);
    write_reg(REG_BIG_ENDIAN, 64'(be));
    write_reg(REG_BIG_TIFF, 64'(big));
    write_reg(REG_FILE_SIZE, fsize);
    write_reg(REG_MAX_TAG_COUNT, max_count);
  endtask

  // Drop valid, wait for every owed result, then for more than the pipeline depth
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Defaults after reset: little endian, classic, file size 0
  task automatic test_reset_defaults();
    send_fields(16'h0100, TYPE_BYTE, 64'd4, 64'hFFA5_5A00, 1'b0);
    send_fields(16'hFFFF, TYPE_SHORT, 64'd2, ~64'd0, 1'b0);
    send_fields(16'h0000, TYPE_LONG, 64'd1, 64'h8765_4321, 1'b0);
    send_fields(16'h0111, TYPE_LONG8, 64'd1, 64'd0, 1'b1);
    send_fields(16'h0102, TYPE_SHORT, 64'd0, 64'd0, 1'b0);
    send_fields(16'h010E, 16'd2, 64'd5, 64'd0, 1'b0);
    send_fields(16'h8000, 16'hFFFF, 64'hFFFF_FFFF, ~64'd0, 1'b0);
    drain();
  endtask

  // Classic, big endian: out-of-line bounds at and past the file end, count limit
  task automatic test_classic_bounds();
    set_config(1'b1, 1'b0, 64'd1000, 64'd16);
    send_fields(16'h0111, TYPE_SHORT, 64'd10, 64'd980, 1'b1);
    send_fields(16'h0111, TYPE_SHORT, 64'd10, 64'd981, 1'b1);
    send_fields(16'h0117, TYPE_BYTE, 64'd5, 64'd1001, 1'b1);
    send_fields(16'h0144, TYPE_LONG, 64'd17, 64'd0, 1'b1);
    send_fields(16'hFFFF, TYPE_LONG, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 1'b1);
    drain();
    write_reg(REG_MAX_TAG_COUNT, 64'd1);
    send_fields(16'h0102, TYPE_BYTE, 64'd3, 64'h00C3_3C81, 1'b0);
    drain();
    // A write past the register map must leave the file size alone
    write_reg(RegUnused, 64'd0);
    send_fields(16'h0111, TYPE_SHORT, 64'd10, 64'd980, 1'b1);
    drain();
  endtask

  // BigTIFF: eight inline elements, size overflow, bounds at the top of the range
  task automatic test_bigtiff();
    set_config(1'b1, 1'b1, ~64'd0, ~64'd0);
    send_fields(16'h0102, TYPE_BYTE, 64'd8, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_fields(16'h0103, TYPE_SHORT, 64'd4, {$urandom, $urandom}, 1'b0);
    send_fields(16'h0111, TYPE_LONG, 64'd2, 64'h8000_0001_7FFF_FFFE, 1'b0);
    send_fields(16'hFFFF, TYPE_LONG8, 64'd1, ~64'd0, 1'b0);
    send_fields(16'h0144, TYPE_LONG8, 64'd2, 64'd7, 1'b1);
    send_fields(16'h0145, TYPE_SHORT, ~64'd0, 64'd0, 1'b1);
    send_fields(16'h0145, TYPE_LONG8, 64'h2000_0000_0000_0000, 64'd0, 1'b1);
    send_fields(16'h0146, TYPE_LONG8, 64'h1FFF_FFFF_FFFF_FFFF, 64'd8, 1'b1);
    send_fields(16'h0146, TYPE_LONG8, 64'h1FFF_FFFF_FFFF_FFFF, 64'd7, 1'b1);
    drain();
    write_reg(REG_BIG_ENDIAN, 64'd0);
    write_reg(REG_MAX_TAG_COUNT, 64'd0);
    send_fields(16'h0001, TYPE_BYTE, 64'd1, 64'd0, 1'b0);
    send_fields(16'h0002, TYPE_BYTE, 64'd0, 64'd0, 1'b0);
    drain();
  endtask

  task automatic randomise_config();
    logic [63:0] fsize;
    logic [63:0] max_count;
    case ($urandom_range(3))
      0:       fsize = '0;
      1:       fsize = ~64'd0;
      default: fsize = 64'($urandom_range(0, 4096));
    endcase
    case ($urandom_range(3))
      0:       max_count = '0;
      1:       max_count = ~64'd0;
      2:       max_count = MaxTagCountReset;
      default: max_count = 64'($urandom_range(0, 40));
    endcase
    set_config(1'($urandom_range(1)), 1'($urandom_range(1)), fsize, max_count);
  endtask

  // Mostly well-formed entries with a supported type; the rest is raw noise or
  // odd type codes. Counts cluster round the inline limit and the count limit.
  function automatic logic [159:0] random_entry();
    logic [15:0]  code;
    logic [63:0]  count;
    logic [63:0]  area;
    int unsigned  esize;
    int unsigned  area_size;
    int unsigned  kind;
    if ($urandom_range(9) == 0) return rand_bits();
    case ($urandom_range(9))
      0, 1:    code = TYPE_BYTE;
      2, 3:    code = TYPE_SHORT;
      4, 5:    code = TYPE_LONG;
      6, 7:    code = TYPE_LONG8;
      8:       code = 16'($urandom);
      default: code = 16'($urandom_range(0, 20));
    endcase
    esize     = (elem_bytes(code) == 0) ? 1 : elem_bytes(code);
    area_size = model_cfg.big_tiff ? 8 : 4;
    kind      = $urandom_range(9);
    case (kind)
      0, 1, 2, 3: count = 64'($urandom_range(0, area_size / esize));
      4, 5, 6:    count = 64'($urandom_range(area_size / esize + 1, 40));
      7:          count = model_cfg.max_tag_count + 64'($urandom_range(2)) - 64'd1;
      8:          count = {$urandom, $urandom};
      default:    count = 64'd1 << $urandom_range(63);
    endcase
    if (kind < 4) return build_entry(16'($urandom), code, count, {$urandom, $urandom}, 1'b0);
    case ($urandom_range(5))
      0:       area = model_cfg.file_size - count * 64'(esize);
      1:       area = model_cfg.file_size - count * 64'(esize) + 64'd1;
      2:       area = model_cfg.file_size + 64'd1;
      3:       area = {$urandom, $urandom};
      default: area = 64'($urandom_range(0, 2048));
    endcase
    return build_entry(16'($urandom), code, count, area, 1'b1);
  endfunction

  // Random traffic at the given idling and stalling odds; re-program the registers
  // every eight requests once the decoder has gone quiet
  task automatic test_random_traffic(input int n, input int unsigned idle,
                                     input int unsigned stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      if (k % 8 == 0) begin
        drain();
        randomise_config();
      end
      send_entry(random_entry());
    end
    drain();
  endtask

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = '0;
    cfg_wdata_i        = '0;
    in_valid_i         = 1'b0;
    entry_bytes_low_i  = '0;
    entry_bytes_mid_i  = '0;
    entry_bytes_high_i = '0;
    out_stall_i        = 1'b0;
    idle_pct           = 0;
    stall_pct          = 0;
    mismatch_count     = 0;
    model_cfg.big_endian    = 1'b0;
    model_cfg.big_tiff      = 1'b0;
    model_cfg.file_size     = '0;
    model_cfg.max_tag_count = MaxTagCountReset;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_classic_bounds();
    test_bigtiff();
    test_random_traffic(21, 0, 0);
    test_random_traffic(21, 73, 0);
    test_random_traffic(21, 0, 73);
    test_random_traffic(21, 26, 26);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
